// File: rtl/fupd_pkg.sv
// Package for the form-urlencoded pair decoder.
// Holds payload structs, status codes, character constants, controller
// states, command/status bundles and the hex digit helper. No dependencies.
package fupd_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       part;
      logic       part_end;
      logic       string_done;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_STOPPED  = 2'd2;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CHAR,
      ST_HEX1,
      ST_HEX2,
      ST_EMIT,
      ST_END,
      ST_STOP,
      ST_DONE,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_DATA,
      EMIT_CLOSE,
      EMIT_STOP,
      EMIT_DONE
   } emit_type;

   localparam logic [1:0] RD_OFF_CHAR = 2'd0;
   localparam logic [1:0] RD_OFF_HEX1 = 2'd1;
   localparam logic [1:0] RD_OFF_HEX2 = 2'd2;

   typedef struct packed {
      logic       accept;
      logic       start_part;
      logic       part_sel;
      logic       rd_en;
      logic [1:0] rd_off;
      logic       take_char;
      logic       zero_v;
      logic       take_hex1;
      logic       take_hex2;
      logic       load_pend;
      emit_type   emit;
      logic       finish;
      logic       finish_stop;
   } cmd_type;

   typedef struct packed {
      logic seg_end;
      logic has_split;
      logic nonempty_amp;
      logic eod_in;
      logic ptr_lt_hi;
      logic has1;
      logic has2;
      logic is_pct;
      logic v_zero;
      logic pend_valid;
      logic out_free;
      logic part;
   } stat_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// File: rtl/fupd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module fupd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/fupd_datapath.sv
// Datapath: segment bookkeeping, segment buffer, byte decoder, pending
// item and result register. Uses fupd_pkg and fupd_ram.
module fupd_datapath #(
   parameter int SEGMENT_DEPTH = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  fupd_pkg::req_type req_payload,
   input  fupd_pkg::cmd_type cmd,
   output fupd_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fupd_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(SEGMENT_DEPTH);
   localparam int LW = $clog2(SEGMENT_DEPTH + 1);
   localparam int PW = $clog2(SEGMENT_DEPTH + 3);
   localparam logic [LW-1:0] DEPTH_L = LW'(SEGMENT_DEPTH);

   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] split_ff, split_in;
   logic          seen_ff, seen_in;
   logic          ovf_ff, ovf_in;
   logic          stopped_ff, stopped_in;
   logic          eod_ff, eod_in;
   logic          zero_ff, zero_in;
   logic          part_ff, part_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [3:0]    val_ff, val_in;
   logic [7:0]    v_ff, v_in;
   logic [7:0]    pend_ff, pend_in;
   logic          pend_valid_ff, pend_valid_in;
   fupd_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          delim;
   logic          room;
   logic          store;
   logic [LW-1:0] hi;
   logic [PW-1:0] hi_p;
   logic [PW-1:0] raddr_p;
   logic [7:0]    rdata;
   logic          out_free;
   logic [1:0]    seg_status;
   fupd_pkg::hex_type hd;

   assign delim = (req_payload.in_byte == fupd_pkg::CHAR_AMP)
                  || (req_payload.in_byte == fupd_pkg::CHAR_NUL);
   assign room  = (len_ff < DEPTH_L);
   assign store = !stopped_ff && !delim && room;
   assign hi    = part_ff ? len_ff : LW'(split_ff);
   assign hi_p  = PW'(hi);
   assign raddr_p = ptr_ff + PW'(cmd.rd_off);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign seg_status = ovf_ff ? fupd_pkg::STATUS_OVERFLOW : fupd_pkg::STATUS_OK;
   assign hd = fupd_pkg::hex_digit(rdata);

   fupd_ram #(
      .WIDTH(8),
      .DEPTH(SEGMENT_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (cmd.accept && store),
      .waddr(len_ff[AW-1:0]),
      .wdata(req_payload.in_byte),
      .re   (cmd.rd_en),
      .raddr(raddr_p[AW-1:0]),
      .rdata(rdata)
   );

   always_comb begin
      stat.seg_end      = !stopped_ff && (delim || req_payload.end_of_data);
      stat.has_split    = seen_ff
                          || (store && req_payload.in_byte == fupd_pkg::CHAR_EQUAL);
      stat.nonempty_amp = (len_ff != '0) || store
                          || (req_payload.in_byte == fupd_pkg::CHAR_AMP);
      stat.eod_in       = req_payload.end_of_data;
      stat.ptr_lt_hi    = (ptr_ff < hi_p);
      stat.has1         = ((ptr_ff + PW'(1)) < hi_p);
      stat.has2         = ((ptr_ff + PW'(2)) < hi_p);
      stat.is_pct       = (rdata == fupd_pkg::CHAR_PERCENT);
      stat.v_zero       = (v_ff == 8'd0);
      stat.pend_valid   = pend_valid_ff;
      stat.out_free     = out_free;
      stat.part         = part_ff;
   end

   always_comb begin
      len_in        = len_ff;
      split_in      = split_ff;
      seen_in       = seen_ff;
      ovf_in        = ovf_ff;
      stopped_in    = stopped_ff;
      eod_in        = eod_ff;
      zero_in       = zero_ff;
      part_in       = part_ff;
      ptr_in        = ptr_ff;
      val_in        = val_ff;
      v_in          = v_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.accept) begin
         eod_in  = req_payload.end_of_data;
         zero_in = (req_payload.in_byte == fupd_pkg::CHAR_NUL);
         if (!stopped_ff && !delim) begin
            if (room) begin
               if (req_payload.in_byte == fupd_pkg::CHAR_EQUAL) begin
                  split_in = len_ff[AW-1:0];
                  seen_in  = 1'b1;
               end
               len_in = len_ff + LW'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end

      if (cmd.start_part) begin
         part_in       = cmd.part_sel;
         ptr_in        = cmd.part_sel ? (PW'(split_ff) + PW'(1)) : '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.take_char) begin
         v_in   = (rdata == fupd_pkg::CHAR_PLUS) ? fupd_pkg::CHAR_SPACE : rdata;
         ptr_in = ptr_ff + PW'(1);
      end
      if (cmd.zero_v) begin
         v_in = 8'd0;
      end
      if (cmd.take_hex1) begin
         val_in = hd.valid ? hd.value : 4'd0;
         v_in   = {4'd0, val_in};
         ptr_in = ptr_ff + PW'(3);
      end
      if (cmd.take_hex2 && hd.valid) begin
         v_in = {val_ff, hd.value};
      end

      rsp_in.string_done = 1'b0;
      rsp_in.last        = 1'b0;
      unique case (cmd.emit)
         fupd_pkg::EMIT_DATA: begin
            rsp_in.out_byte   = pend_ff;
            rsp_in.byte_valid = 1'b1;
            rsp_in.part       = part_ff;
            rsp_in.part_end   = 1'b0;
            rsp_in.status     = seg_status;
            rsp_valid_in      = 1'b1;
         end
         fupd_pkg::EMIT_CLOSE: begin
            rsp_in.out_byte    = pend_valid_ff ? pend_ff : 8'd0;
            rsp_in.byte_valid  = pend_valid_ff;
            rsp_in.part        = part_ff;
            rsp_in.part_end    = 1'b1;
            rsp_in.status      = seg_status;
            rsp_in.last        = part_ff;
            rsp_in.string_done = part_ff && eod_ff;
            rsp_valid_in       = 1'b1;
            pend_valid_in      = 1'b0;
         end
         fupd_pkg::EMIT_STOP: begin
            rsp_in.out_byte    = 8'd0;
            rsp_in.byte_valid  = 1'b0;
            rsp_in.part        = 1'b0;
            rsp_in.part_end    = 1'b0;
            rsp_in.status      = fupd_pkg::STATUS_STOPPED;
            rsp_in.last        = 1'b1;
            rsp_in.string_done = eod_ff;
            rsp_valid_in       = 1'b1;
         end
         fupd_pkg::EMIT_DONE: begin
            rsp_in.out_byte    = 8'd0;
            rsp_in.byte_valid  = 1'b0;
            rsp_in.part        = 1'b0;
            rsp_in.part_end    = 1'b0;
            rsp_in.status      = fupd_pkg::STATUS_OK;
            rsp_in.last        = 1'b1;
            rsp_in.string_done = 1'b1;
            rsp_valid_in       = 1'b1;
         end
         default: begin
            rsp_in.string_done = rsp_ff.string_done;
            rsp_in.last        = rsp_ff.last;
         end
      endcase

      if (cmd.load_pend) begin
         pend_in       = v_ff;
         pend_valid_in = 1'b1;
      end

      if (cmd.finish) begin
         len_in     = '0;
         split_in   = '0;
         seen_in    = 1'b0;
         ovf_in     = 1'b0;
         stopped_in = eod_ff ? 1'b0 : (zero_ff || cmd.finish_stop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         split_ff      <= '0;
         seen_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
         stopped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         split_ff      <= split_in;
         seen_ff       <= seen_in;
         ovf_ff        <= ovf_in;
         stopped_ff    <= stopped_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eod_ff  <= eod_in;
      zero_ff <= zero_in;
      part_ff <= part_in;
      ptr_ff  <= ptr_in;
      val_ff  <= val_in;
      v_ff    <= v_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/fupd_ctrl.sv
// Controller: sequences byte intake, replay of the buffered segment and
// marker results. Uses fupd_pkg; drives the datapath by command bundle.
module fupd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fupd_pkg::stat_type stat,
   output fupd_pkg::cmd_type  cmd
);

   fupd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fupd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit = fupd_pkg::EMIT_NONE;
      req_ready = 1'b0;

      unique case (state_ff)
         fupd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.seg_end && stat.has_split) begin
                  cmd.start_part = 1'b1;
                  cmd.part_sel   = 1'b0;
                  state_in       = fupd_pkg::ST_READ;
               end else if (stat.seg_end && stat.nonempty_amp) begin
                  state_in = fupd_pkg::ST_STOP;
               end else if (stat.eod_in) begin
                  state_in = fupd_pkg::ST_DONE;
               end else if (stat.seg_end) begin
                  state_in = fupd_pkg::ST_FIN;
               end
            end
         end
         fupd_pkg::ST_READ: begin
            if (stat.ptr_lt_hi) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_off = fupd_pkg::RD_OFF_CHAR;
               state_in   = fupd_pkg::ST_CHAR;
            end else begin
               state_in = fupd_pkg::ST_END;
            end
         end
         fupd_pkg::ST_CHAR: begin
            if (!stat.is_pct) begin
               cmd.take_char = 1'b1;
               state_in      = fupd_pkg::ST_EMIT;
            end else if (stat.has1) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_off = fupd_pkg::RD_OFF_HEX1;
               state_in   = fupd_pkg::ST_HEX1;
            end else begin
               cmd.zero_v = 1'b1;
               state_in   = fupd_pkg::ST_EMIT;
            end
         end
         fupd_pkg::ST_HEX1: begin
            cmd.take_hex1 = 1'b1;
            if (stat.has2) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_off = fupd_pkg::RD_OFF_HEX2;
               state_in   = fupd_pkg::ST_HEX2;
            end else begin
               state_in = fupd_pkg::ST_EMIT;
            end
         end
         fupd_pkg::ST_HEX2: begin
            cmd.take_hex2 = 1'b1;
            state_in      = fupd_pkg::ST_EMIT;
         end
         fupd_pkg::ST_EMIT: begin
            if (stat.v_zero) begin
               state_in = fupd_pkg::ST_END;
            end else if (!stat.pend_valid) begin
               cmd.load_pend = 1'b1;
               state_in      = fupd_pkg::ST_READ;
            end else if (stat.out_free) begin
               cmd.emit      = fupd_pkg::EMIT_DATA;
               cmd.load_pend = 1'b1;
               state_in      = fupd_pkg::ST_READ;
            end
         end
         fupd_pkg::ST_END: begin
            if (stat.out_free) begin
               cmd.emit = fupd_pkg::EMIT_CLOSE;
               if (!stat.part) begin
                  cmd.start_part = 1'b1;
                  cmd.part_sel   = 1'b1;
                  state_in       = fupd_pkg::ST_READ;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = fupd_pkg::ST_IDLE;
               end
            end
         end
         fupd_pkg::ST_STOP: begin
            if (stat.out_free) begin
               cmd.emit        = fupd_pkg::EMIT_STOP;
               cmd.finish      = 1'b1;
               cmd.finish_stop = 1'b1;
               state_in        = fupd_pkg::ST_IDLE;
            end
         end
         fupd_pkg::ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit   = fupd_pkg::EMIT_DONE;
               cmd.finish = 1'b1;
               state_in   = fupd_pkg::ST_IDLE;
            end
         end
         fupd_pkg::ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = fupd_pkg::ST_IDLE;
         end
         default: begin
            state_in = fupd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/form_urlencoded_pair_decoder_unit.sv
// Form-urlencoded pair decoder, top level.
// Joins fupd_ctrl and fupd_datapath; uses fupd_pkg for payload types.
//
// Usage: raw encoded bytes enter on the req_ channel (valid/ready), one
// transfer per byte, end_of_data flagging the last byte of a string.
// Decoded name and value bytes, stop and done markers leave on the rsp_
// channel (valid/ready) as one struct per transfer; last marks the final
// result caused by an input byte.
// A byte that does not end a segment is taken at once and gives no result.
// A byte that ends a segment holds req_ready low while the segment buffer
// is replayed: a plain byte passes READ, CHAR and EMIT, an escape adds
// HEX1 and, with room, HEX2, a name or value end passes READ and END, and a
// marker passes STOP or DONE. The single registered read port of the
// segment buffer sets these steps. Each decoded byte waits in a pending
// register until the next one is decoded or its part ends, then moves to
// the output register; a marker waits only for that register to be free.
// While the receiver stalls, replay pauses at the next result; between
// segments input is still taken until a segment end starts the next replay.
// Reset (synchronous, active high) empties the segment, clears the stopped
// condition and drops any unsent result; the buffer needs no clearing pass.
module form_urlencoded_pair_decoder_unit #(
   parameter int SEGMENT_DEPTH = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fupd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fupd_pkg::rsp_type rsp_payload
);

   fupd_pkg::cmd_type  cmd;
   fupd_pkg::stat_type stat;

   fupd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   fupd_datapath #(
      .SEGMENT_DEPTH(SEGMENT_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

// File: bench/tb_form_urlencoded_pair_decoder_unit.sv
`timescale 1ns / 100ps
// Testbench for form_urlencoded_pair_decoder_unit: sends form-encoded strings byte by byte
// and checks each decoded name/value item and marker against an in-bench decoder.
// Depends on fupd_pkg and the unit's RTL.
module tb_form_urlencoded_pair_decoder_unit;

   localparam int unsigned SEG_DEPTH    = 48;
   localparam int unsigned NOT_HEX      = 16;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned TAIL_CYCLES  = 200;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   fupd_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   fupd_pkg::rsp_type rsp_payload;

   logic [7:0]  held_segment [SEG_DEPTH];
   int unsigned held_length = 0;
   int unsigned split_index = 0;
   bit          split_found = 1'b0;
   bit          stopped     = 1'b0;
   bit          truncated   = 1'b0;

   fupd_pkg::rsp_type step_items [$];
   fupd_pkg::rsp_type expected_items [$];
   fupd_pkg::rsp_type wanted;
   logic [7:0]  text_q [$];
   string       word_chars = "abcmXYZ0179-_.~";
   string       hex_chars  = "0123456789abcdefABCDEFgG:/";

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_left      = 0;
   int unsigned items_sent     = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned error_count    = 0;

   form_urlencoded_pair_decoder_unit #(
      .SEGMENT_DEPTH(SEG_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #6 clock = ~clock;

   function automatic int unsigned hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return NOT_HEX;
   endfunction

   function automatic void clear_segment();
      held_length = 0;
      split_index = 0;
      split_found = 1'b0;
      truncated   = 1'b0;
   endfunction

   function automatic void decode_part(int unsigned lo, int unsigned hi, logic part_sel,
                                       logic [1:0] code);
      int unsigned idx, first_digit, second_digit, value, count;
      logic [7:0]  c, a, b;
      fupd_pkg::rsp_type item;
      idx   = lo;
      count = 0;
      if (hi > SEG_DEPTH) hi = SEG_DEPTH;
      while (idx < hi) begin
         c = held_segment[idx];
         if (c == fupd_pkg::CHAR_PERCENT) begin
            a = (idx + 1 < hi) ? held_segment[idx + 1] : fupd_pkg::CHAR_NUL;
            b = (a != fupd_pkg::CHAR_NUL && idx + 2 < hi) ? held_segment[idx + 2]
                                                          : fupd_pkg::CHAR_NUL;
            first_digit  = hex_nibble(a);
            second_digit = hex_nibble(b);
            value = (first_digit < NOT_HEX) ? first_digit : 0;
            if (second_digit < NOT_HEX) value = value * 16 + second_digit;
            idx += 3;
         end else if (c == fupd_pkg::CHAR_PLUS) begin
            value = 32'(fupd_pkg::CHAR_SPACE);
            idx++;
         end else begin
            value = 32'(c);
            idx++;
         end
         if (value == 0) break;
         item            = '0;
         item.out_byte   = value[7:0];
         item.byte_valid = 1'b1;
         item.part       = part_sel;
         item.status     = code;
         step_items.push_back(item);
         count++;
      end
      if (count == 0) begin
         item          = '0;
         item.part     = part_sel;
         item.part_end = 1'b1;
         item.status   = code;
         step_items.push_back(item);
      end else begin
         step_items[step_items.size() - 1].part_end = 1'b1;
      end
   endfunction

   function automatic void predict_decode(fupd_pkg::req_type item);
      bit         at_delim;
      logic [1:0] code;
      fupd_pkg::rsp_type marker;
      step_items.delete();
      at_delim = (item.in_byte == fupd_pkg::CHAR_AMP) || (item.in_byte == fupd_pkg::CHAR_NUL);
      if (!stopped) begin
         if (!at_delim) begin
            if (held_length < SEG_DEPTH) begin
               if (item.in_byte == fupd_pkg::CHAR_EQUAL) begin
                  split_index = held_length;
                  split_found = 1'b1;
               end
               held_segment[held_length] = item.in_byte;
               held_length++;
            end else begin
               truncated = 1'b1;
            end
         end
         if (at_delim || item.end_of_data) begin
            code = truncated ? fupd_pkg::STATUS_OVERFLOW : fupd_pkg::STATUS_OK;
            if (split_found) begin
               decode_part(0, split_index, 1'b0, code);
               decode_part(split_index + 1, held_length, 1'b1, code);
            end else if (held_length > 0 || item.in_byte == fupd_pkg::CHAR_AMP) begin
               marker        = '0;
               marker.status = fupd_pkg::STATUS_STOPPED;
               step_items.push_back(marker);
               stopped = 1'b1;
            end
            if (item.in_byte == fupd_pkg::CHAR_NUL) stopped = 1'b1;
            clear_segment();
         end
      end
      if (item.end_of_data) begin
         if (step_items.size() == 0) begin
            marker        = '0;
            marker.status = fupd_pkg::STATUS_OK;
            step_items.push_back(marker);
         end
         step_items[step_items.size() - 1].string_done = 1'b1;
         clear_segment();
         stopped = 1'b0;
      end
      if (step_items.size() > 0) begin
         step_items[step_items.size() - 1].last = 1'b1;
         foreach (step_items[k]) expected_items.push_back(step_items[k]);
      end
   endfunction

   function automatic string fmt_rsp(fupd_pkg::rsp_type r);
      return $sformatf("{byte %h valid %b part %b end %b done %b status %0d last %b}",
                       r.out_byte, r.byte_valid, r.part, r.part_end, r.string_done,
                       r.status, r.last);
   endfunction

   // call at a falling edge; returns at the falling edge after the transfer with valid held
   task automatic send_byte(logic [7:0] value, logic eod);
      fupd_pkg::req_type item;
      item.in_byte     = value;
      item.end_of_data = eod;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_decode(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s, bit eod_last);
      int k;
      for (k = 0; k < s.len(); k++) send_byte(s[k], eod_last && (k == s.len() - 1));
   endtask

   function automatic void append_part(int unsigned length);
      int unsigned k, roll;
      for (k = 0; k < length; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            text_q.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
         end else if (roll < 67) begin
            text_q.push_back(fupd_pkg::CHAR_PLUS);
         end else if (roll < 87) begin
            text_q.push_back(fupd_pkg::CHAR_PERCENT);
            text_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
            text_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
         end else if (roll < 93) begin
            text_q.push_back(fupd_pkg::CHAR_PERCENT);
         end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   task automatic send_random_string();
      int unsigned seg_count, k, ending;
      text_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         seg_count = $urandom_range(1, 3);
         for (k = 0; k < seg_count; k++) begin
            if ($urandom_range(0, 19) == 0) begin
               append_part($urandom_range(16, 30));
               text_q.push_back(fupd_pkg::CHAR_EQUAL);
               append_part($urandom_range(16, 30));
            end else begin
               append_part($urandom_range(0, 4));
               if ($urandom_range(0, 11) != 0) text_q.push_back(fupd_pkg::CHAR_EQUAL);
               append_part($urandom_range(0, 6));
            end
            if (k + 1 < seg_count) text_q.push_back(fupd_pkg::CHAR_AMP);
         end
         ending = $urandom_range(0, 3);
         if (ending == 1) begin
            text_q.push_back(fupd_pkg::CHAR_AMP);
         end else if (ending >= 2) begin
            text_q.push_back(fupd_pkg::CHAR_NUL);
         end
         if (ending == 3) begin
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
         end
         if (text_q.size() == 0) text_q.push_back(word_chars[0]);
      end
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_items.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed_strings();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_text("%4A+=", 1'b0);
      send_byte(fupd_pkg::CHAR_AMP, 1'b0);
      send_text("=%G5%", 1'b1);
      send_text("b", 1'b0);
      send_byte(fupd_pkg::CHAR_AMP, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(fupd_pkg::CHAR_NUL, 1'b1);
      send_text("%4z=v", 1'b0);
      send_byte(fupd_pkg::CHAR_NUL, 1'b0);
      send_text("x", 1'b1);
      send_text("%00=k", 1'b0);
      send_byte(fupd_pkg::CHAR_AMP, 1'b1);
      send_byte(fupd_pkg::CHAR_AMP, 1'b1);
      send_byte(fupd_pkg::CHAR_NUL, 1'b1);
   endtask

   task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                      int unsigned count);
      int unsigned stop_at;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at        = items_sent + count;
      while (items_sent < stop_at) send_random_string();
   endtask

   // hold the receiver off while the sender keeps offering bytes
   task automatic test_receiver_holdoff();
      int unsigned stop_at;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      stop_at = items_sent + 40;
      while (items_sent < stop_at) send_random_string();
   endtask

   task automatic test_drained_pauses();
      send_idle_pct  = 10;
      recv_stall_pct = 30;
      repeat (3) begin
         send_random_string();
         wait_for_results();
      end
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_items.size() == 0) begin
            error_count++;
            $display("%0t ns: unexpected transfer, expected none, actual %s",
                     $time, fmt_rsp(rsp_payload));
         end else begin
            wanted = expected_items.pop_front();
            if (rsp_payload !== wanted) begin
               error_count++;
               $display("%0t ns: mismatch, expected %s, actual %s",
                        $time, fmt_rsp(wanted), fmt_rsp(rsp_payload));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_strings();
      test_random_traffic(0, 0, 60);
      test_random_traffic(78, 0, 60);
      test_random_traffic(0, 78, 60);
      test_random_traffic(18, 18, 60);
      test_receiver_holdoff();
      test_drained_pauses();
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_items.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
